// ===== hdl/bezier_path_bounds_defines.svh =====
// Assertion macros for the path bounding box block.
// Included by the top level; no other dependencies.
`ifndef BEZIER_PATH_BOUNDS_DEFINES_SVH
`define BEZIER_PATH_BOUNDS_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define BPB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bezier_path_bounds: check failed");
// Next-cycle implication, checked out of reset
`define BPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bezier_path_bounds: check failed");
`else
`define BPB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/bpb_pkg.sv =====
// Shared types and constants for the path bounding box block.
// No dependencies; used by bpb_divsqrt and bezier_path_bounds.
package bpb_pkg;

    localparam int COORD_W = 32;
    localparam int KIND_W  = 3;
    localparam int T_BITS  = 30;
    localparam int T_W     = T_BITS + 1;
    localparam int DIV_W   = 35;
    localparam int RAD_W   = 64;
    localparam int RES_W   = 32;
    localparam int CNT_W   = 5;
    localparam int COEF_W  = 36;
    localparam int SC_W    = 30;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 31;
    localparam int PROD_W  = 64;
    localparam int LERP_W  = COORD_W + 1;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(T_BITS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(RAD_W / 2 - 1);
    localparam logic [RAD_W-1:0] SQRT_TOP  = RAD_W'(1) << (RAD_W - 2);
    localparam logic [RES_W-1:0] T_ONE     = RES_W'(1) << T_BITS;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Segment kinds
    localparam logic [KIND_W-1:0] K_MOVE  = 3'd0;
    localparam logic [KIND_W-1:0] K_LINE  = 3'd1;
    localparam logic [KIND_W-1:0] K_QUAD  = 3'd2;
    localparam logic [KIND_W-1:0] K_CUBIC = 3'd3;
    localparam logic [KIND_W-1:0] K_END   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
    } t_seg_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic signed [COORD_W-1:0] box_right;
        logic signed [COORD_W-1:0] box_bottom;
    } t_box_out;

    typedef enum logic {DS_DIV, DS_SQRT} t_ds_op;

    typedef struct packed {
        logic   start;
        t_ds_op op;
    } t_ds_req;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [RES_W-1:0] res;
    } t_ds_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_AXIS, S_COEF, S_NORM, S_MUL_BB, S_MUL_AC, S_DISC,
        S_WAIT_S, S_ROOT, S_WAIT_T, S_LMUL, S_LADD, S_AFTER, S_NEXT
    } t_state;

    typedef enum logic [2:0] {
        LS_AB, LS_BC, LS_CD, LS_ABC, LS_BCD, LS_OUT, LS_QOUT
    } t_lstep;

endpackage

// ===== hdl/bezier_path_bounds.sv =====
// Top level of the path bounding box block: sequencer, shared multiplier and box state.
// Depends on bpb_pkg, bpb_divsqrt and bezier_path_bounds_defines.svh.
//
// Usage: segments arrive on the input channel (i_in_valid / o_in_ready / i_in_data),
// one beat per segment. Move, line and end beats leave the sequencer idle; a move
// or line folds its points into the running box at once. A quadratic or cubic beat
// holds o_in_ready low while each axis is worked through by one shared 33x31
// multiplier and one shared divide / square-root unit (30-step divide, 32-step root).
// A quadratic axis needs one divide; a cubic axis at most the root and two divides.
// An end beat loads the box into the output register (o_out_valid / i_out_ready /
// o_out_data) on the cycle it is taken, and the box is cleared for the next path;
// an empty path gives all zeros. Kinds 5 to 7 are taken and dropped.
// While a box waits on a stalled receiver, o_in_ready stays low and no beat is taken;
// a new beat can go in on the cycle the waiting box is taken. Reset (i_rst_n low,
// synchronous) empties the box and the output register; it needs no clearing pass.
`include "bezier_path_bounds_defines.svh"
module bezier_path_bounds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpb_pkg::t_seg_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpb_pkg::t_box_out o_out_data
);
    import bpb_pkg::*;

    t_state r_state, n_state;
    t_seg_in r_item;
    logic    r_axis, r_cubic, r_root;
    t_lstep  r_step, n_step;

    logic signed [COORD_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [COORD_W-1:0] r_ab, r_bc, r_cd, r_abc, r_bcd;
    logic [COEF_W-1:0] r_ma, r_mb, r_mc, r_m;
    logic              r_sa, r_sb, r_sc;
    logic [PROD_W-1:0] r_prod, r_bb;
    logic              r_neg;
    logic [RES_W-1:0]  r_s;
    logic [T_W-1:0]    r_t;

    logic signed [COORD_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic     r_any;
    t_box_out r_out;
    logic     r_out_valid;

    logic accept;
    t_ds_req ds_req;
    t_ds_rsp ds_rsp;
    logic signed [DIV_W-1:0] ds_num, ds_den;
    logic [PROD_W-1:0] disc;

    function automatic logic signed [COORD_W-1:0] f_min(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_max(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    // Handshake
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Points folded in on the accept cycle
    logic signed [COORD_W-1:0] pt_x, pt_y;
    logic signed [COORD_W-1:0] a_min_x, a_max_x, a_min_y, a_max_y;
    always_comb begin
        if (i_in_data.kind == K_QUAD) begin
            pt_x = i_in_data.p2_x;
            pt_y = i_in_data.p2_y;
        end else if (i_in_data.kind == K_CUBIC) begin
            pt_x = i_in_data.p3_x;
            pt_y = i_in_data.p3_y;
        end else begin
            pt_x = i_in_data.p0_x;
            pt_y = i_in_data.p0_y;
        end
        a_min_x = f_min(r_min_x, pt_x);
        a_max_x = f_max(r_max_x, pt_x);
        a_min_y = f_min(r_min_y, pt_y);
        a_max_y = f_max(r_max_y, pt_y);
        if (i_in_data.kind == K_LINE) begin
            a_min_x = f_min(a_min_x, i_in_data.p1_x);
            a_max_x = f_max(a_max_x, i_in_data.p1_x);
            a_min_y = f_min(a_min_y, i_in_data.p1_y);
            a_max_y = f_max(a_max_y, i_in_data.p1_y);
        end
    end

    // Derivative coefficients of one cubic axis
    logic signed [COEF_W-1:0] xa, xb, xc, xd, t3, ca, cb, cc;
    logic [COEF_W-1:0] ma0, mb0, mc0, m0;
    always_comb begin
        xa  = COEF_W'(r_pa);
        xb  = COEF_W'(r_pb);
        xc  = COEF_W'(r_pc);
        xd  = COEF_W'(r_pd);
        t3  = xb - xc;
        ca  = xd - xa + t3 + (t3 <<< 1);
        cb  = (xa - (xb <<< 1) + xc) <<< 1;
        cc  = xb - xa;
        ma0 = ca[COEF_W-1] ? COEF_W'(-ca) : COEF_W'(ca);
        mb0 = cb[COEF_W-1] ? COEF_W'(-cb) : COEF_W'(cb);
        mc0 = cc[COEF_W-1] ? COEF_W'(-cc) : COEF_W'(cc);
        m0  = (ma0 > mb0) ? ma0 : mb0;
        m0  = (mc0 > m0) ? mc0 : m0;
    end

    // Divider operands for the three kinds of root
    logic [DIV_W-1:0] mav, mbv, mcv, nb, sv;
    logic signed [DIV_W-1:0] pa_d, pb_d, pc_d;
    always_comb begin
        mav  = DIV_W'(r_ma);
        mbv  = DIV_W'(r_mb);
        mcv  = DIV_W'(r_mc);
        nb   = r_sb ? mbv : DIV_W'(-mbv);
        sv   = DIV_W'(r_s);
        pa_d = DIV_W'(r_pa);
        pb_d = DIV_W'(r_pb);
        pc_d = DIV_W'(r_pc);
        unique case (r_state)
            S_COEF: begin
                ds_num = pa_d - pb_d;
                ds_den = pa_d - (pb_d <<< 1) + pc_d;
            end
            S_NORM: begin
                ds_num = r_sc ? mcv : DIV_W'(-mcv);
                ds_den = r_sb ? DIV_W'(-mbv) : mbv;
            end
            default: begin
                ds_num = r_root ? nb - sv : nb + sv;
                ds_den = r_sa ? DIV_W'(-(mav << 1)) : DIV_W'(mav << 1);
            end
        endcase
    end

    // Discriminant from b*b and a*c
    assign disc = r_neg ? r_bb + (r_prod << 2) : r_bb - (r_prod << 2);

    // Lerp operand select
    logic signed [COORD_W-1:0] lp, lq;
    logic signed [LERP_W-1:0]  ld, lsum;
    logic [LERP_W-1:0] lm, ls;
    logic              lneg, lfinal;
    logic signed [COORD_W-1:0] lres;
    always_comb begin
        unique case (r_step)
            LS_AB:   begin lp = r_pa;  lq = r_pb;  end
            LS_BC:   begin lp = r_pb;  lq = r_pc;  end
            LS_CD:   begin lp = r_pc;  lq = r_pd;  end
            LS_ABC:  begin lp = r_ab;  lq = r_bc;  end
            LS_BCD:  begin lp = r_bc;  lq = r_cd;  end
            LS_OUT:  begin lp = r_abc; lq = r_bcd; end
            LS_QOUT: begin lp = r_ab;  lq = r_bc;  end
            default: begin lp = r_pa;  lq = r_pb;  end
        endcase
        ld     = LERP_W'(lq) - LERP_W'(lp);
        lneg   = ld[LERP_W-1];
        lm     = lneg ? LERP_W'(-ld) : LERP_W'(ld);
        ls     = r_prod[T_BITS +: LERP_W];
        lsum   = r_neg ? LERP_W'(lp) - ls : LERP_W'(lp) + ls;
        lres   = lsum[COORD_W-1:0];
        lfinal = (r_step == LS_OUT) || (r_step == LS_QOUT);
        unique case (r_step)
            LS_AB:   n_step = LS_BC;
            LS_BC:   n_step = r_cubic ? LS_CD : LS_QOUT;
            LS_CD:   n_step = LS_ABC;
            LS_ABC:  n_step = LS_BCD;
            LS_BCD:  n_step = LS_OUT;
            default: n_step = LS_AB;
        endcase
    end

    // Shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    always_comb begin
        unique case (r_state)
            S_MUL_BB: begin mul_a = MUL_A_W'(r_mb); mul_b = MUL_B_W'(r_mb); end
            S_MUL_AC: begin mul_a = MUL_A_W'(r_ma); mul_b = MUL_B_W'(r_mc); end
            S_LMUL:   begin mul_a = lm;             mul_b = r_t;            end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
        mul_p = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit launches
    always_comb begin
        n_state      = r_state;
        ds_req.start = 1'b0;
        ds_req.op    = DS_DIV;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_data.kind == K_QUAD || i_in_data.kind == K_CUBIC)) begin
                    n_state = S_AXIS;
                end
            end
            S_AXIS: n_state = S_COEF;
            S_COEF: begin
                if (!r_cubic) begin
                    ds_req.start = 1'b1;
                    n_state      = S_WAIT_T;
                end else if (m0 == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_m[COEF_W-1:SC_W] == '0 && r_m[SC_W-1]) begin
                    if (r_ma != '0) begin
                        n_state = S_MUL_BB;
                    end else if (r_mb != '0) begin
                        ds_req.start = 1'b1;
                        n_state      = S_WAIT_T;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_MUL_BB: n_state = S_MUL_AC;
            S_MUL_AC: n_state = S_DISC;
            S_DISC: begin
                if (disc[PROD_W-1]) begin
                    n_state = S_NEXT;
                end else begin
                    ds_req.start = 1'b1;
                    ds_req.op    = DS_SQRT;
                    n_state      = S_WAIT_S;
                end
            end
            S_WAIT_S: begin
                if (ds_rsp.done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                ds_req.start = 1'b1;
                n_state      = S_WAIT_T;
            end
            S_WAIT_T: begin
                if (ds_rsp.done) begin
                    n_state = ds_rsp.ok ? S_LMUL : S_AFTER;
                end
            end
            S_LMUL: n_state = S_LADD;
            S_LADD: n_state = lfinal ? S_AFTER : S_LMUL;
            S_AFTER: begin
                n_state = (r_cubic && r_ma != '0 && !r_root) ? S_ROOT : S_NEXT;
            end
            S_NEXT: n_state = r_axis ? S_IDLE : S_AXIS;
            default: n_state = S_IDLE;
        endcase
    end

    // Working registers per sequencer step
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_item  <= i_in_data;
                    r_cubic <= i_in_data.kind == K_CUBIC;
                    r_axis  <= 1'b0;
                end
            end
            S_AXIS: begin
                r_pa   <= r_axis ? r_item.p0_y : r_item.p0_x;
                r_pb   <= r_axis ? r_item.p1_y : r_item.p1_x;
                r_pc   <= r_axis ? r_item.p2_y : r_item.p2_x;
                r_pd   <= r_axis ? r_item.p3_y : r_item.p3_x;
                r_root <= 1'b0;
            end
            S_COEF: begin
                r_ma <= ma0;
                r_mb <= mb0;
                r_mc <= mc0;
                r_m  <= m0;
                r_sa <= ca[COEF_W-1];
                r_sb <= cb[COEF_W-1];
                r_sc <= cc[COEF_W-1];
            end
            S_NORM: begin
                // Scale until the largest magnitude lies in [2^29, 2^30)
                if (r_m[COEF_W-1:SC_W] != '0) begin
                    r_ma <= r_ma >> 1;
                    r_mb <= r_mb >> 1;
                    r_mc <= r_mc >> 1;
                    r_m  <= r_m >> 1;
                end else if (!r_m[SC_W-1]) begin
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb << 1;
                    r_mc <= r_mc << 1;
                    r_m  <= r_m << 1;
                end
            end
            S_MUL_BB: r_prod <= mul_p;
            S_MUL_AC: begin
                r_bb   <= r_prod;
                r_prod <= mul_p;
                r_neg  <= r_sa ^ r_sc;
            end
            S_WAIT_S: begin
                if (ds_rsp.done) begin
                    r_s <= ds_rsp.res;
                end
            end
            S_WAIT_T: begin
                if (ds_rsp.done && ds_rsp.ok) begin
                    r_t    <= ds_rsp.res[T_W-1:0];
                    r_step <= LS_AB;
                end
            end
            S_LMUL: begin
                r_prod <= mul_p;
                r_neg  <= lneg;
            end
            S_LADD: begin
                unique case (r_step)
                    LS_AB:   r_ab  <= lres;
                    LS_BC:   r_bc  <= lres;
                    LS_CD:   r_cd  <= lres;
                    LS_ABC:  r_abc <= lres;
                    LS_BCD:  r_bcd <= lres;
                    default: ;
                endcase
                r_step <= n_step;
            end
            S_AFTER: begin
                if (r_cubic && r_ma != '0 && !r_root) begin
                    r_root <= 1'b1;
                end
            end
            S_NEXT: r_axis <= 1'b1;
            default: ;
        endcase
    end

    // Running box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= COORD_MAX;
            r_min_y <= COORD_MAX;
            r_max_x <= COORD_MIN;
            r_max_y <= COORD_MIN;
            r_any   <= 1'b0;
        end else if (accept && i_in_data.kind == K_END) begin
            r_min_x <= COORD_MAX;
            r_min_y <= COORD_MAX;
            r_max_x <= COORD_MIN;
            r_max_y <= COORD_MIN;
            r_any   <= 1'b0;
        end else if (accept && i_in_data.kind <= K_CUBIC) begin
            r_min_x <= a_min_x;
            r_max_x <= a_max_x;
            r_min_y <= a_min_y;
            r_max_y <= a_max_y;
            r_any   <= 1'b1;
        end else if (r_state == S_LADD && lfinal) begin
            if (r_axis) begin
                r_min_y <= f_min(r_min_y, lres);
                r_max_y <= f_max(r_max_y, lres);
            end else begin
                r_min_x <= f_min(r_min_x, lres);
                r_max_x <= f_max(r_max_x, lres);
            end
        end
    end

    // Output register: load on end beat, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_data.kind == K_END) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.kind == K_END) begin
            r_out.box_left   <= r_any ? r_min_x : '0;
            r_out.box_top    <= r_any ? r_min_y : '0;
            r_out.box_right  <= r_any ? r_max_x : '0;
            r_out.box_bottom <= r_any ? r_max_y : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bpb_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .i_rad   (disc),
        .o_rsp   (ds_rsp)
    );

    // Checks
    `BPB_ASSERT_IMPL(a_box_ordered, i_clk, i_rst_n, r_any, (r_min_x <= r_max_x) && (r_min_y <= r_max_y))
    `BPB_ASSERT_IMPL(a_box_empty, i_clk, i_rst_n, !r_any, (r_min_x == COORD_MAX) && (r_max_y == COORD_MIN))
    `BPB_ASSERT_IMPL(a_t_range, i_clk, i_rst_n, r_state == S_LMUL, r_t <= T_W'(T_ONE))

endmodule

// ===== hdl/bpb_divsqrt.sv =====
// Shared iterative unit: restoring fraction divide (t in Q2.30) and integer square root.
// Depends on bpb_pkg.
module bpb_divsqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpb_pkg::t_ds_req                  i_req,
    input  logic signed [bpb_pkg::DIV_W-1:0]  i_num,
    input  logic signed [bpb_pkg::DIV_W-1:0]  i_den,
    input  logic        [bpb_pkg::RAD_W-1:0]  i_rad,
    output bpb_pkg::t_ds_rsp                  o_rsp
);
    import bpb_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_ok;
    t_ds_op           r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rem;
    logic [RAD_W-1:0] r_acc;
    logic [RAD_W-1:0] r_aux;
    logic [RES_W-1:0] r_res;

    logic             num_neg, den_neg;
    logic [DIV_W-1:0] num_mag, den_mag;
    logic [DIV_W:0]   rem2;
    logic             div_ge;
    logic [RAD_W-1:0] trial;
    logic             sq_ge;
    logic [RAD_W-1:0] n_rem, n_acc;
    logic             last;

    // Operand magnitudes for the launch checks
    always_comb begin
        num_neg = i_num[DIV_W-1];
        den_neg = i_den[DIV_W-1];
        num_mag = num_neg ? DIV_W'(-i_num) : DIV_W'(i_num);
        den_mag = den_neg ? DIV_W'(-i_den) : DIV_W'(i_den);
    end

    // One step of divide or root
    always_comb begin
        rem2   = {r_rem[DIV_W-1:0], 1'b0};
        div_ge = rem2 >= {1'b0, r_aux[DIV_W-1:0]};
        trial  = r_acc + r_aux;
        sq_ge  = r_rem >= trial;
        if (r_op == DS_DIV) begin
            n_rem = div_ge ? RAD_W'(rem2 - {1'b0, r_aux[DIV_W-1:0]}) : RAD_W'(rem2);
            n_acc = {r_acc[RAD_W-2:0], div_ge};
            last  = r_cnt == DIV_LAST;
        end else begin
            n_rem = sq_ge ? r_rem - trial : r_rem;
            n_acc = sq_ge ? (r_acc >> 1) + r_aux : r_acc >> 1;
            last  = r_cnt == SQRT_LAST;
        end
    end

    // Control: busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.op == DS_SQRT) begin
                    r_busy <= 1'b1;
                end else begin
                    priority if (i_den == '0 || i_num == '0 || num_neg != den_neg
                                 || num_mag >= den_mag) begin
                        r_done <= 1'b1;
                    end else begin
                        r_busy <= 1'b1;
                    end
                end
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: launch, iterate, hold result
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_acc <= '0;
            if (i_req.op == DS_SQRT) begin
                r_rem <= i_rad;
                r_aux <= SQRT_TOP;
            end else begin
                r_rem <= RAD_W'(num_mag);
                r_aux <= RAD_W'(den_mag);
                // Trivial outcomes settle here
                priority if (i_den == '0) begin
                    r_ok <= 1'b0;
                end else if (i_num == '0) begin
                    r_ok  <= 1'b1;
                    r_res <= '0;
                end else if (num_neg != den_neg || num_mag > den_mag) begin
                    r_ok <= 1'b0;
                end else begin
                    r_ok  <= 1'b1;
                    r_res <= T_ONE;
                end
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt + 1'b1;
            if (r_op == DS_SQRT) begin
                r_aux <= r_aux >> 2;
            end
            if (last) begin
                r_ok  <= 1'b1;
                r_res <= n_acc[RES_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ok   = r_ok;
    assign o_rsp.res  = r_res;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for bezier_path_bounds: drives segment beats, predicts the path box.
// Depends on bpb_pkg and the bezier_path_bounds RTL; no files read.
`timescale 1ns / 1ps

module tb_top;
    import bpb_pkg::*;

    localparam logic [KIND_W-1:0] K_SPARE = 3'd5;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_seg_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_box_out o_out_data;
    int       n_errors;

    bezier_path_bounds u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_errors++;
    endtask

    // Path box predictor and store of expected boxes
    class box_board;
        longint   lo_x, hi_x, lo_y, hi_y;
        bit       seen;
        t_box_out pending[$];

        function new();
            clear_box();
        endfunction

        function void clear_box();
            lo_x = 64'sd2147483647;
            lo_y = 64'sd2147483647;
            hi_x = -64'sd2147483648;
            hi_y = -64'sd2147483648;
            seen = 0;
        endfunction

        static function longint magn(longint v);
            return v < 0 ? -v : v;
        endfunction

        static function void widen(longint v, ref longint lo, ref longint hi);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        endfunction

        // Parameter as Q2.30 if num/den lies in [0,1]
        static function bit param_of(longint num, longint den, output longint t);
            longint nm, dm, r, q;
            t = 0;
            if (den == 0) return 0;
            if (num == 0) return 1;
            if ((num < 0) != (den < 0)) return 0;
            nm = magn(num);
            dm = magn(den);
            if (nm > dm) return 0;
            if (nm == dm) begin
                t = 64'd1 << 30;
                return 1;
            end
            r = nm;
            q = 0;
            for (int i = 0; i < 30; i++) begin
                r = r <<< 1;
                q = q <<< 1;
                if (r >= dm) begin
                    r -= dm;
                    q |= 1;
                end
            end
            t = q;
            return 1;
        endfunction

        static function longint blend(longint p, longint q, longint t);
            longint d, m, s;
            logic [63:0] ph, ql;
            if (t >= (64'd1 << 30)) return q;
            d = q - p;
            m = magn(d);
            ph = m * (t >> 15);
            ql = m * (t & 32'h7fff);
            s = (ph >> 15) + (((ph & 64'h7fff) + (ql >> 15)) >> 15);
            return d < 0 ? p - s : p + s;
        endfunction

        static function longint cubic_at(longint t, longint a, longint b, longint c, longint d);
            longint ab, bc, cd;
            ab = blend(a, b, t);
            bc = blend(b, c, t);
            cd = blend(c, d, t);
            return blend(blend(ab, bc, t), blend(bc, cd, t), t);
        endfunction

        static function longint isqrt(logic [63:0] v);
            logic [63:0] res, bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > v) bits >>= 2;
            while (bits != 0) begin
                if (v >= res + bits) begin
                    v -= res + bits;
                    res = (res >> 1) + bits;
                end else begin
                    res >>= 1;
                end
                bits >>= 2;
            end
            return res;
        endfunction

        static function void quad_axis(longint a, longint b, longint c,
                                       ref longint lo, ref longint hi);
            longint t;
            if (param_of(a - b, a - 2 * b + c, t))
                widen(blend(blend(a, b, t), blend(b, c, t), t), lo, hi);
        endfunction

        static function void cubic_axis(longint pa, longint pb, longint pc, longint pd,
                                        ref longint lo, ref longint hi);
            longint a, b, c, ma, mb, mc, m, t, disc, s;
            a = -pa + 3 * pb - 3 * pc + pd;
            b = 2 * (pa - 2 * pb + pc);
            c = pb - pa;
            ma = magn(a);
            mb = magn(b);
            mc = magn(c);
            m = ma > mb ? ma : mb;
            if (mc > m) m = mc;
            if (m == 0) return;
            while (m >= (64'd1 << 30)) begin
                ma >>= 1; mb >>= 1; mc >>= 1; m >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                ma <<= 1; mb <<= 1; mc <<= 1; m <<= 1;
            end
            a = a < 0 ? -ma : ma;
            b = b < 0 ? -mb : mb;
            c = c < 0 ? -mc : mc;
            if (a != 0) begin
                disc = b * b - 4 * a * c;
                if (disc < 0) return;
                s = isqrt(disc);
                // both roots are tried, each on its own
                if (param_of(-b + s, 2 * a, t)) widen(cubic_at(t, pa, pb, pc, pd), lo, hi);
                if (param_of(-b - s, 2 * a, t)) widen(cubic_at(t, pa, pb, pc, pd), lo, hi);
            end else if (b != 0) begin
                if (param_of(-c, b, t)) widen(cubic_at(t, pa, pb, pc, pd), lo, hi);
            end
        endfunction

        // Fold an accepted segment beat into the box
        function void note_segment(t_seg_in s);
            t_box_out bx;
            case (s.kind)
                K_MOVE: begin
                    widen(s.p0_x, lo_x, hi_x); widen(s.p0_y, lo_y, hi_y);
                end
                K_LINE: begin
                    widen(s.p0_x, lo_x, hi_x); widen(s.p0_y, lo_y, hi_y);
                    widen(s.p1_x, lo_x, hi_x); widen(s.p1_y, lo_y, hi_y);
                end
                K_QUAD: begin
                    widen(s.p2_x, lo_x, hi_x); widen(s.p2_y, lo_y, hi_y);
                    quad_axis(s.p0_x, s.p1_x, s.p2_x, lo_x, hi_x);
                    quad_axis(s.p0_y, s.p1_y, s.p2_y, lo_y, hi_y);
                end
                K_CUBIC: begin
                    widen(s.p3_x, lo_x, hi_x); widen(s.p3_y, lo_y, hi_y);
                    cubic_axis(s.p0_x, s.p1_x, s.p2_x, s.p3_x, lo_x, hi_x);
                    cubic_axis(s.p0_y, s.p1_y, s.p2_y, s.p3_y, lo_y, hi_y);
                end
                K_END: begin
                    if (seen) begin
                        bx.box_left = 32'(lo_x); bx.box_top = 32'(lo_y);
                        bx.box_right = 32'(hi_x); bx.box_bottom = 32'(hi_y);
                    end else begin
                        bx = '0;
                    end
                    pending.push_back(bx);
                    clear_box();
                    return;
                end
                default: return;
            endcase
            seen = 1;
        endfunction

        // Compare a delivered box with the oldest one waiting
        task check_box(t_box_out got);
            t_box_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected box", got.box_left, 0);
                return;
            end
            want = pending.pop_front();
            if (got.box_left != want.box_left)
                report_mismatch("box_left", got.box_left, want.box_left);
            if (got.box_top != want.box_top)
                report_mismatch("box_top", got.box_top, want.box_top);
            if (got.box_right != want.box_right)
                report_mismatch("box_right", got.box_right, want.box_right);
            if (got.box_bottom != want.box_bottom)
                report_mismatch("box_bottom", got.box_bottom, want.box_bottom);
        endtask
    endclass

    box_board board;

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one beat and hold it until taken; valid stays up for a following beat
    task automatic send_segment(t_seg_in s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_segment(s);
    endtask

    // Drop valid after the last beat taken
    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            3: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    function automatic t_seg_in rand_segment(logic [KIND_W-1:0] kind);
        t_seg_in s;
        s.kind = kind;
        s.p0_x = rand_coord(); s.p0_y = rand_coord();
        s.p1_x = rand_coord(); s.p1_y = rand_coord();
        s.p2_x = rand_coord(); s.p2_y = rand_coord();
        s.p3_x = rand_coord(); s.p3_y = rand_coord();
        return s;
    endfunction

    function automatic t_seg_in make_seg(logic [KIND_W-1:0] kind, int x0, int y0, int x1,
                                         int y1, int x2, int y2, int x3, int y3);
        t_seg_in s;
        s.kind = kind;
        s.p0_x = x0; s.p0_y = y0; s.p1_x = x1; s.p1_y = y1;
        s.p2_x = x2; s.p2_y = y2; s.p3_x = x3; s.p3_y = y3;
        return s;
    endfunction

    // Receiver: stall at random, check each box taken
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_box(o_out_data);
        end
    end

    // Stimulus
    initial begin
        localparam int ONE = 32'h10000;
        int n;
        logic [KIND_W-1:0] k;
        board = new();
        n_errors = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty path, spare kind, extremes, roots at the ends and none
        send_segment(make_seg(K_END, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_SPARE, 5, 5, 5, 5, 5, 5, 5, 5));
        send_segment(make_seg(K_END, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_MOVE, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_LINE, 32'h80000000, 32'h7fffffff, -1, -1, 0, 0, 0, 0));
        send_segment(make_seg(K_END, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_QUAD, 0, 0, ONE, 2 * ONE, 2 * ONE, 0, 0, 0));
        send_segment(make_seg(K_QUAD, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 0, 0));
        send_segment(make_seg(K_QUAD, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_END, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_CUBIC, 0, 0, 0, 3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 0));
        send_segment(make_seg(K_CUBIC, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE));
        send_segment(make_seg(K_CUBIC, 0, 0, 4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 0, 0));
        send_segment(make_seg(K_CUBIC, 5, 5, 5, 5, 5, 5, 5, 5));
        send_segment(make_seg(K_CUBIC, 0, 0, ONE, 0, ONE, 0, 0, 0));
        send_segment(make_seg(K_END, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(K_CUBIC, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h7fffffff));
        send_segment(make_seg(K_QUAD, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                              32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0));
        send_segment(make_seg(K_END, -1, -1, -1, -1, -1, -1, -1, -1));

        // Random paths: move, several segments, end; some noise beats
        n = 0;
        while (n < 1000) begin
            if (n > 500 && n < 520) begin
                // hold off until every box has come back
                release_input();
                while (board.pending.size() != 0) @(posedge i_clk);
                repeat (10) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) != 0) send_segment(rand_segment(K_MOVE));
            repeat ($urandom_range(0, 6)) begin
                k = KIND_W'($urandom_range(0, 7));
                if (k > K_CUBIC) k = KIND_W'($urandom_range(K_MOVE, 7));
                if (k == K_END) k = K_LINE;
                send_segment(rand_segment(k));
                n++;
            end
            send_segment(rand_segment(K_END));
            n += 2;
        end

        // Drain
        release_input();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (n_errors == 0 && board.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Run limit
    initial begin
        #40ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
